[hdl/assert_macros.svh]
// Assertion shorthands shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define GBA_ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define GBA_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hdl/gba_pkg.sv]
package gba_pkg;

  localparam int MAX_FRAMES_DEF = 128;
  localparam int PIX_W          = 10;
  localparam int NUM_PIX        = 9;
  localparam int LEN_W          = 8;
  localparam int BINS           = 6;
  localparam int BIN_W          = 3;
  localparam int MEAN_W         = 13;
  localparam int S_DATA_W       = 104;
  localparam int M_DATA_W       = 32;
  localparam int M_USER_W       = BIN_W;

  localparam logic [BIN_W-1:0] LAST_BIN = 3'd5;
  localparam logic [LEN_W-1:0] MIN_LEN  = 8'd6;

  // n / 6 == (n * 171) >> 10 for every 8-bit n
  localparam int DIV6_MUL   = 171;
  localparam int DIV6_SHIFT = 10;

  typedef struct packed {
    logic [BIN_W-1:0] bin;
    logic             last;
  } tag_t;

  localparam int TAG_W = $bits(tag_t);

  function automatic int bin_max(input int max_frames);
    return max_frames / BINS + 1;
  endfunction

  function automatic int cnt_w(input int max_frames);
    return $clog2(bin_max(max_frames) + 1);
  endfunction

  // |sum| <= bin_max * 3 * (2^PIX_W - 1), plus sign
  function automatic int acc_w(input int max_frames);
    return PIX_W + 3 + $clog2(bin_max(max_frames));
  endfunction

  function automatic int entry_w(input int max_frames);
    return 2 * acc_w(max_frames) + cnt_w(max_frames) + TAG_W;
  endfunction

  // Bins that get one extra frame for a given remainder of N / 6.
  function automatic logic extra_frame(input logic [2:0] rest, input logic [BIN_W-1:0] bin);
    logic [BINS-1:0] sel;
    logic            hit;
    case (rest)
      3'd1:    sel = 6'b100000;
      3'd2:    sel = 6'b100100;
      3'd3:    sel = 6'b101010;
      3'd4:    sel = 6'b111010;
      3'd5:    sel = 6'b111011;
      default: sel = 6'b000000;
    endcase
    case (bin)
      3'd0:    hit = sel[0];
      3'd1:    hit = sel[1];
      3'd2:    hit = sel[2];
      3'd3:    hit = sel[3];
      3'd4:    hit = sel[4];
      3'd5:    hit = sel[5];
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

endpackage

[hdl/gba_front.sv]
module gba_front #(
  parameter int MAX_FRAMES = gba_pkg::MAX_FRAMES_DEF
) (
  input  logic                                          clk,
  input  logic                                          rst,
  input  logic                                          s_axis_tvalid,
  output logic                                          s_axis_tready,
  input  logic [gba_pkg::S_DATA_W-1:0]                  s_axis_tdata,
  output logic                                          push_valid,
  input  logic                                          push_ready,
  output logic [gba_pkg::entry_w(MAX_FRAMES)-1:0]       push_data
);
  import gba_pkg::*;

  localparam int CW = cnt_w(MAX_FRAMES);
  localparam int AW = acc_w(MAX_FRAMES);
  localparam int FW = PIX_W + 3;
  localparam int SW = PIX_W + 2;

  logic                  in_gesture;
  logic [CW-1:0]         len_base;
  logic [2:0]            len_rest;
  logic [BIN_W-1:0]      cur_bin;
  logic [CW-1:0]         cnt;
  logic signed [AW-1:0]  xacc;
  logic signed [AW-1:0]  yacc;

  logic [PIX_W-1:0]      pix [NUM_PIX];
  logic [SW-1:0]         left_sum, right_sum, top_sum, bot_sum;
  logic signed [FW-1:0]  fx, fy;
  logic [LEN_W-1:0]      len_in, len_clamp, q6;
  logic [2*LEN_W-1:0]    prod;
  logic [LEN_W-1:0]      rem6;
  logic                  first;
  logic [CW-1:0]         base;
  logic [2:0]            rest;
  logic [BIN_W-1:0]      bin_now;
  logic [CW-1:0]         size;
  logic [CW-1:0]         cnt_next;
  logic signed [AW-1:0]  xacc_next, yacc_next;
  logic                  close_bin;
  logic                  last;
  logic                  accept;
  tag_t                  tag;

  always_comb begin
    for (int k = 0; k < NUM_PIX; k++) begin
      pix[k] = s_axis_tdata[k*PIX_W +: PIX_W];
    end
  end

  assign left_sum  = SW'(pix[0]) + SW'(pix[3]) + SW'(pix[6]);
  assign right_sum = SW'(pix[2]) + SW'(pix[5]) + SW'(pix[8]);
  assign top_sum   = SW'(pix[0]) + SW'(pix[1]) + SW'(pix[2]);
  assign bot_sum   = SW'(pix[6]) + SW'(pix[7]) + SW'(pix[8]);
  assign fx = $signed({1'b0, left_sum}) - $signed({1'b0, right_sum});
  assign fy = $signed({1'b0, top_sum}) - $signed({1'b0, bot_sum});

  // Length: clamp, then split into N / 6 and N % 6
  assign len_in = s_axis_tdata[NUM_PIX*PIX_W +: LEN_W];
  always_comb begin
    len_clamp = len_in;
    if (len_in < MIN_LEN) begin
      len_clamp = MIN_LEN;
    end
    if (len_in > LEN_W'(MAX_FRAMES)) begin
      len_clamp = LEN_W'(MAX_FRAMES);
    end
  end
  assign prod = {{LEN_W{1'b0}}, len_clamp} * (2*LEN_W)'(DIV6_MUL);
  assign q6   = LEN_W'(prod >> DIV6_SHIFT);
  assign rem6 = len_clamp - (q6 << 2) - (q6 << 1);

  assign first   = !in_gesture;
  assign base    = first ? CW'(q6) : len_base;
  assign rest    = first ? rem6[2:0] : len_rest;
  assign bin_now = first ? '0 : cur_bin;
  assign size    = base + CW'(extra_frame(rest, bin_now));

  assign cnt_next  = (first ? '0 : cnt) + CW'(1);
  assign xacc_next = (first ? '0 : xacc) + AW'(fx);
  assign yacc_next = (first ? '0 : yacc) + AW'(fy);
  assign close_bin = (cnt_next == size);
  assign last      = (bin_now == LAST_BIN);

  assign s_axis_tready = push_ready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign tag.bin    = bin_now;
  assign tag.last   = last;
  assign push_valid = accept && close_bin;
  assign push_data  = {tag, size, yacc_next, xacc_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      in_gesture <= 1'b0;
      cur_bin    <= '0;
      cnt        <= '0;
    end else if (accept) begin
      // gesture ends when its sixth bin closes
      in_gesture <= !(close_bin && last);
      len_base   <= base;
      len_rest   <= rest;
      if (close_bin) begin
        cnt  <= '0;
        xacc <= '0;
        yacc <= '0;
        if (last) begin
          cur_bin <= '0;
        end else begin
          cur_bin <= bin_now + BIN_W'(1);
        end
      end else begin
        cnt     <= cnt_next;
        xacc    <= xacc_next;
        yacc    <= yacc_next;
        cur_bin <= bin_now;
      end
    end
  end

endmodule

[hdl/gba_queue.sv]
module gba_queue #(
  parameter int W = 8
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push_valid,
  output logic         push_ready,
  input  logic [W-1:0] push_data,
  output logic         pop_valid,
  input  logic         pop_ready,
  output logic [W-1:0] pop_data
);

  // two-entry FIFO of closed bins
  logic [W-1:0] slot [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   count;
  logic         do_push;
  logic         do_pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = slot[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

[hdl/gba_div.sv]
module gba_div #(
  parameter int MAX_FRAMES = gba_pkg::MAX_FRAMES_DEF
) (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    pop_valid,
  output logic                                    pop_ready,
  input  logic [gba_pkg::entry_w(MAX_FRAMES)-1:0] pop_data,
  output logic                                    m_axis_tvalid,
  input  logic                                    m_axis_tready,
  output logic [gba_pkg::M_DATA_W-1:0]            m_axis_tdata,
  output logic [gba_pkg::M_USER_W-1:0]            m_axis_tuser,
  output logic                                    m_axis_tlast
);
  import gba_pkg::*;

  localparam int CW = cnt_w(MAX_FRAMES);
  localparam int AW = acc_w(MAX_FRAMES);
  localparam int SW = $clog2(AW + 1);
  localparam int RW = CW + AW;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;

  logic                 state;
  logic [SW-1:0]        step;
  logic [RW-1:0]        xrq, yrq;
  logic [CW-1:0]        divisor;
  logic                 x_neg, y_neg;
  tag_t                 tag;
  logic                 out_valid;
  logic [MEAN_W-1:0]    out_x, out_y;
  tag_t                 out_tag;

  logic signed [AW-1:0] in_x, in_y;
  logic [CW-1:0]        in_size;
  tag_t                 in_tag;
  logic [AW-1:0]        in_xmag, in_ymag;
  logic                 done;
  logic                 out_free;
  logic [MEAN_W-1:0]    xq, yq;

  // one restoring step: {remainder, quotient/dividend}
  function automatic logic [RW-1:0] div_step(input logic [RW-1:0] rq, input logic [CW-1:0] d);
    logic [CW:0]   rem_sh;
    logic [CW:0]   diff;
    logic [RW-1:0] res;
    rem_sh = {rq[RW-1:AW], rq[AW-1]};
    diff   = rem_sh - {1'b0, d};
    if (rem_sh >= {1'b0, d}) begin
      res = {diff[CW-1:0], rq[AW-2:0], 1'b1};
    end else begin
      res = {rem_sh[CW-1:0], rq[AW-2:0], 1'b0};
    end
    return res;
  endfunction

  assign {in_tag, in_size, in_y, in_x} = pop_data;
  assign in_xmag = in_x[AW-1] ? AW'(-in_x) : AW'(in_x);
  assign in_ymag = in_y[AW-1] ? AW'(-in_y) : AW'(in_y);

  assign pop_ready = (state == ST_IDLE);
  assign done      = (step == SW'(AW));
  assign out_free  = !out_valid || m_axis_tready;
  assign xq        = xrq[MEAN_W-1:0];
  assign yq        = yrq[MEAN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      step  <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (pop_valid) begin
            state <= ST_RUN;
            step  <= '0;
          end
        end
        ST_RUN: begin
          if (!done) begin
            step <= step + SW'(1);
          end else if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && pop_valid) begin
      xrq     <= {{CW{1'b0}}, in_xmag};
      yrq     <= {{CW{1'b0}}, in_ymag};
      divisor <= in_size;
      x_neg   <= in_x[AW-1];
      y_neg   <= in_y[AW-1];
      tag     <= in_tag;
    end else if (state == ST_RUN && !done) begin
      xrq <= div_step(xrq, divisor);
      yrq <= div_step(yrq, divisor);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_RUN && done && out_free) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_RUN && done && out_free) begin
      out_x   <= x_neg ? -xq : xq;
      out_y   <= y_neg ? -yq : yq;
      out_tag <= tag;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(M_DATA_W - 2*MEAN_W){1'b0}}, out_y, out_x};
  assign m_axis_tuser  = out_tag.bin;
  assign m_axis_tlast  = out_tag.last;

endmodule

[hdl/gradient_bin_average_3x3.sv]
// Binned gradient of 3x3 light-sensor frames. Each input item is one frame;
// the first frame of a gesture also carries the gesture length N (clamped to
// 6..MAX_FRAMES). N is cut into six bins of N/6 frames, the remainder adding
// one frame to fixed bins. Per frame the block sums left-minus-right columns
// (x) and top-minus-bottom rows (y); when a bin closes it emits both sums
// divided by the bin's frame count, truncated toward zero, tagged with the
// bin number, with tlast on the sixth bin. Frames are taken one per cycle
// while the two-entry bin queue has room; each closed bin is loaded into the
// shared restoring divider, which runs one step per accumulator bit (18 at
// MAX_FRAMES = 128) and then hands the quotient to the output register before
// it takes the next bin, and a result waiting in the output register does not
// stop frames being taken.
module gradient_bin_average_3x3 #(
  parameter int MAX_FRAMES = gba_pkg::MAX_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // pix_0 .. pix_8 (10 bits each), gesture_length (8 bits), zero pad
  input  logic [gba_pkg::S_DATA_W-1:0]   s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // x_mean (13 bits signed), y_mean (13 bits signed), zero pad
  output logic [gba_pkg::M_DATA_W-1:0]   m_axis_tdata,
  // bin_index (3 bits)
  output logic [gba_pkg::M_USER_W-1:0]   m_axis_tuser,
  // last_bin
  output logic                           m_axis_tlast
);
  import gba_pkg::*;

  localparam int EW = entry_w(MAX_FRAMES);

  // front to queue
  logic          push_valid;
  logic          push_ready;
  logic [EW-1:0] push_data;
  // queue to divider
  logic          pop_valid;
  logic          pop_ready;
  logic [EW-1:0] pop_data;

  // Front: unpack frame, form x/y, accumulate, track bin boundaries.
  gba_front #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .push_valid    (push_valid),
    .push_ready    (push_ready),
    .push_data     (push_data)
  );

  // Closed bins wait here so the front keeps taking frames during a divide.
  gba_queue #(
    .W (EW)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  // Back: x and y divided in parallel lanes, one quotient bit per cycle.
  gba_div #(
    .MAX_FRAMES (MAX_FRAMES)
  ) u_div (
    .clk           (clk),
    .rst           (rst),
    .pop_valid     (pop_valid),
    .pop_ready     (pop_ready),
    .pop_data      (pop_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

[hdl/gba_checker.sv]
`include "assert_macros.svh"

module gba_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         m_axis_tvalid,
  input logic                         m_axis_tready,
  input logic [gba_pkg::M_DATA_W-1:0] m_axis_tdata,
  input logic [gba_pkg::M_USER_W-1:0] m_axis_tuser,
  input logic                         m_axis_tlast
);
  import gba_pkg::*;

  // stalled result holds
  `GBA_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "result changed while stalled")

  // tlast marks exactly the sixth bin
  `GBA_ASSERT_IMPL(a_last_bin, clk, rst, m_axis_tvalid, m_axis_tlast == (m_axis_tuser == LAST_BIN), "tlast does not match bin index")

  // bin index stays within the six bins
  `GBA_ASSERT_IMPL(a_bin_range, clk, rst, m_axis_tvalid, m_axis_tuser <= LAST_BIN, "bin index out of range")

  // nothing is presented right after reset
  `GBA_ASSERT_IMPL(a_reset_quiet, clk, rst, $past(rst), !m_axis_tvalid, "result valid right after reset")

endmodule

bind gradient_bin_average_3x3 gba_checker u_gba_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);

[tb/sv/gradient_bin_average_3x3_tb.sv]
module gradient_bin_average_3x3_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gba_pkg::*;

  // Bit b set: bin b takes one extra frame for a given remainder of N / 6.
  localparam logic [BINS-1:0] EXTRA_BIN_MASK [BINS] =
    '{6'h00, 6'h20, 6'h24, 6'h2A, 6'h3A, 6'h3B};

  localparam int TOTAL_FRAMES = 650;
  localparam int PIX_MAX      = (1 << PIX_W) - 1;
  localparam int LEN_LSB      = NUM_PIX * PIX_W;

  typedef logic [PIX_W-1:0] pixel_t;
  typedef pixel_t frame_pix_t [NUM_PIX];

  // One closed bin as the block reports it.
  typedef struct packed {
    logic signed [MEAN_W-1:0] x_mean;
    logic signed [MEAN_W-1:0] y_mean;
    logic [BIN_W-1:0]         bin_index;
    logic                     last_bin;
  } bin_mean_t;

  // Tracks the gesture/bin state of the block and the bin means still owed.
  class bin_mean_scoreboard;
    bin_mean_t        owed_means[$];
    int               errors;
    bit               in_gesture;
    int               gesture_frames;
    logic [BIN_W-1:0] open_bin;
    int               bin_frames;
    int               x_sum;
    int               y_sum;

    function new();
      errors     = 0;
      in_gesture = 0;
      open_bin   = '0;
      bin_frames = 0;
      x_sum      = 0;
      y_sum      = 0;
    endfunction

    // Frame accepted by the block: advance the bin state, owe a mean on close.
    function void note_frame(logic [S_DATA_W-1:0] data);
      int        px [NUM_PIX];
      int        len;
      int        bin_len;
      bin_mean_t mean;
      for (int i = 0; i < NUM_PIX; i++) px[i] = int'(data[i*PIX_W +: PIX_W]);
      if (!in_gesture) begin
        // first frame of a gesture: latch N, clamped to 6..MAX_FRAMES
        len = int'(data[LEN_LSB +: LEN_W]);
        if (len < BINS) len = BINS;
        if (len > MAX_FRAMES_DEF) len = MAX_FRAMES_DEF;
        gesture_frames = len;
        in_gesture     = 1;
        open_bin       = '0;
        bin_frames     = 0;
        x_sum          = 0;
        y_sum          = 0;
      end
      x_sum += (px[0] + px[3] + px[6]) - (px[2] + px[5] + px[8]);
      y_sum += (px[0] + px[1] + px[2]) - (px[6] + px[7] + px[8]);
      bin_frames++;
      bin_len = gesture_frames / BINS +
                int'(EXTRA_BIN_MASK[gesture_frames % BINS][open_bin]);
      if (bin_frames == bin_len) begin
        // int division truncates toward zero, as the block must
        mean.x_mean    = x_sum / bin_len;
        mean.y_mean    = y_sum / bin_len;
        mean.bin_index = open_bin;
        mean.last_bin  = (open_bin == LAST_BIN);
        owed_means.push_back(mean);
        x_sum      = 0;
        y_sum      = 0;
        bin_frames = 0;
        if (open_bin == LAST_BIN) begin
          open_bin   = '0;
          in_gesture = 0;
        end else begin
          open_bin = open_bin + 1'b1;
        end
      end
    endfunction

    function void check_result(logic [M_DATA_W-1:0] data, logic [M_USER_W-1:0] bin,
                               logic last);
      bin_mean_t got;
      bin_mean_t want;
      got.x_mean    = data[MEAN_W-1:0];
      got.y_mean    = data[2*MEAN_W-1:MEAN_W];
      got.bin_index = bin;
      got.last_bin  = last;
      if (owed_means.size() == 0) begin
        errors++;
        $display("%0t: unexpected result x_mean=%0d y_mean=%0d bin=%0d last=%0b",
                 $time, got.x_mean, got.y_mean, got.bin_index, got.last_bin);
        return;
      end
      want = owed_means.pop_front();
      if (got.x_mean !== want.x_mean) begin
        errors++;
        $display("%0t: x_mean expected %0d actual %0d", $time, want.x_mean, got.x_mean);
      end
      if (got.y_mean !== want.y_mean) begin
        errors++;
        $display("%0t: y_mean expected %0d actual %0d", $time, want.y_mean, got.y_mean);
      end
      if (got.bin_index !== want.bin_index) begin
        errors++;
        $display("%0t: bin_index expected %0d actual %0d", $time, want.bin_index,
                 got.bin_index);
      end
      if (got.last_bin !== want.last_bin) begin
        errors++;
        $display("%0t: last_bin expected %0b actual %0b", $time, want.last_bin, got.last_bin);
      end
    endfunction

    function int owed();
      return owed_means.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [S_DATA_W-1:0]   s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [M_DATA_W-1:0]   m_axis_tdata;
  logic [M_USER_W-1:0]   m_axis_tuser;
  logic                  m_axis_tlast;

  bin_mean_scoreboard sb;
  int                 frames_sent;
  int                 send_idle_pct;   // chance per item of a sender gap cycle
  int                 recv_stall_pct;  // chance per cycle of tready low

  gradient_bin_average_3x3 dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // tdata: pix_0 .. pix_8 from bit 0 up, then gesture_length, zero pad on top.
  function automatic logic [S_DATA_W-1:0] pack_frame(frame_pix_t px, logic [LEN_W-1:0] len);
    logic [S_DATA_W-1:0] data;
    data = '0;
    for (int i = 0; i < NUM_PIX; i++) data[i*PIX_W +: PIX_W] = px[i];
    data[LEN_LSB +: LEN_W] = len;
    return data;
  endfunction

  // Idling profile follows progress through the stimulus: sender busy and
  // receiver choked first, then the reverse, then full throughput.
  function automatic void pick_idling();
    if (frames_sent < TOTAL_FRAMES / 3) begin
      send_idle_pct  = 16;
      recv_stall_pct = 65;
    end else if (frames_sent < 2 * TOTAL_FRAMES / 3) begin
      send_idle_pct  = 65;
      recv_stall_pct = 16;
    end else begin
      send_idle_pct  = 0;
      recv_stall_pct = 0;
    end
  endfunction

  // Offer one frame; tvalid is only dropped while idling so back-to-back
  // items keep it high with no glitch.
  task automatic send_frame(frame_pix_t px, logic [LEN_W-1:0] len);
    pick_idling();
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= S_DATA_W'({$urandom, $urandom, $urandom, $urandom});
      @(posedge clk);
    end
    s_axis_tdata  <= pack_frame(px, len);
    s_axis_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_frame(s_axis_tdata);
    frames_sent++;
  endtask

  // Pixel content: fully random, or only rail values so the bin sums swing
  // to their extremes.
  function automatic frame_pix_t random_pixels(bit rails);
    frame_pix_t px;
    for (int i = 0; i < NUM_PIX; i++)
      px[i] = rails ? ($urandom_range(1) ? pixel_t'(PIX_MAX) : '0)
                    : pixel_t'($urandom_range(PIX_MAX));
    return px;
  endfunction

  // One whole gesture of random frames; the length field of the later
  // frames is junk the block must ignore.
  task automatic send_gesture(logic [LEN_W-1:0] len);
    int  n;
    bit  rails;
    n     = (len < BINS) ? BINS : ((len > MAX_FRAMES_DEF) ? MAX_FRAMES_DEF : int'(len));
    rails = ($urandom_range(3) == 0);
    for (int f = 0; f < n; f++)
      send_frame(random_pixels(rails), (f == 0) ? len : LEN_W'($urandom_range(255)));
  endtask

  // Receiver: check every accepted result, re-roll tready each cycle.
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready)
        sb.check_result(m_axis_tdata, m_axis_tuser, m_axis_tlast);
      m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    frame_pix_t       px;
    int               pick;
    logic [LEN_W-1:0] len;
    sb             = new();
    frames_sent    = 0;
    send_idle_pct  = 16;
    recv_stall_pct = 65;
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Gesture with length 0, raised to 6: one frame per bin, so each bin
    // mean is a single frame's gradient, from pixels at the rails.
    px = '{10'h3FF, 10'h000, 10'h000, 10'h3FF, 10'h000, 10'h000, 10'h3FF, 10'h000, 10'h000};
    send_frame(px, 8'd0);                                   // x at +max
    px = '{10'h000, 10'h000, 10'h3FF, 10'h000, 10'h000, 10'h3FF, 10'h000, 10'h000, 10'h3FF};
    send_frame(px, 8'hFF);                                  // x at -max
    px = '{10'h3FF, 10'h3FF, 10'h3FF, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000};
    send_frame(px, 8'h55);                                  // y at +max
    px = '{10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h000, 10'h3FF, 10'h3FF, 10'h3FF};
    send_frame(px, 8'hAA);                                  // y at -max
    px = '{default: 10'h3FF};
    send_frame(px, 8'd3);                                   // flat bright
    px = '{default: 10'h000};
    send_frame(px, 8'd128);                                 // flat dark

    // Length 7: bin 5 takes two frames; a negative gradient plus zero halves exactly.
    for (int f = 0; f < 5; f++) send_frame(random_pixels(1), f == 0 ? 8'd7 : 8'd0);
    px = '{10'h000, 10'h000, 10'h3FF, 10'h000, 10'h000, 10'h3FF, 10'h3FF, 10'h3FF, 10'h3FF};
    send_frame(px, 8'd200);
    px = '{default: 10'h000};
    send_frame(px, 8'd1);

    // Length 11: remainder 5, every bin but bin 2 gets an extra frame.
    for (int f = 0; f < 11; f++) send_frame(random_pixels(0), f == 0 ? 8'd11 : 8'd6);

    // Random gestures: mostly short ones, some lengths below 6, a few at or
    // beyond the frame limit.
    while (frames_sent < TOTAL_FRAMES) begin
      pick = $urandom_range(29);
      if (pick < 3)       len = LEN_W'($urandom_range(BINS - 1));
      else if (pick == 3) len = LEN_W'(BINS);
      else if (pick == 4) len = LEN_W'(MAX_FRAMES_DEF);
      else if (pick == 5) len = LEN_W'($urandom_range(255, MAX_FRAMES_DEF + 1));
      else                len = LEN_W'($urandom_range(40, BINS + 1));
      send_gesture(len);
    end
    s_axis_tvalid <= 1'b0;

    // Drain, then leave room for any stray result to show up.
    while (sb.owed() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule
